// ===== hdl/sfm_pkg.sv =====
package sfm_pkg;

	localparam int MAX_NEEDLE    = 8;
	localparam int POSITION_BITS = 16;
	localparam int BYTE_BITS     = 8;
	localparam int NEEDLE_BITS   = MAX_NEEDLE * BYTE_BITS;
	localparam int LEN_BITS      = $clog2(MAX_NEEDLE + 1);
	localparam int CFG_LEN_BITS  = 4;
	localparam int CNT_BITS      = POSITION_BITS + 1;
	localparam int OUT_POS_BITS  = 16;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 1;

	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_NEEDLE_BYTES  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_NEEDLE_LENGTH = CFG_IDX_BITS'(1);

	localparam logic [BYTE_BITS-1:0] TERMINATOR = '0;

	// one queued haystack beat, already classified
	typedef struct packed {
		logic                 is_term;
		logic [BYTE_BITS-1:0] data;
	} item_t;

	typedef struct packed {
		logic [NEEDLE_BITS-1:0]  needle;
		logic [CFG_LEN_BITS-1:0] length;
	} cfg_t;

	typedef struct packed {
		logic  full;
		logic  empty;
		item_t head;
	} queue_status_t;

	// needle length after clamping and cutting at the first zero byte
	function automatic logic [LEN_BITS-1:0] eff_len(
		input logic [NEEDLE_BITS-1:0]  needle,
		input logic [CFG_LEN_BITS-1:0] length
	);
		logic [LEN_BITS-1:0] len;
		logic                cut;
		len = (length > CFG_LEN_BITS'(MAX_NEEDLE)) ? LEN_BITS'(MAX_NEEDLE)
		                                           : LEN_BITS'(length);
		cut = 1'b0;
		for (int i = 0; i < MAX_NEEDLE; i++) begin
			if (!cut && (LEN_BITS'(i) < len) &&
			    (needle[i*BYTE_BITS +: BYTE_BITS] == TERMINATOR)) begin
				len = LEN_BITS'(i);
				cut = 1'b1;
			end
		end
		return len;
	endfunction

endpackage

// ===== hdl/sfm_front.sv =====
module sfm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  logic [sfm_pkg::BYTE_BITS-1:0] text_byte,
	input  logic                          q_full,
	output logic                          q_push,
	output sfm_pkg::item_t                q_item
);

	logic           valid_s1;
	sfm_pkg::item_t item_s1;
	logic           take;

	assign q_push     = valid_s1 && !q_full;
	assign text_stall = valid_s1 && !q_full ? 1'b0 : valid_s1;
	assign take       = text_valid && !text_stall;
	assign q_item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.is_term <= (text_byte == sfm_pkg::TERMINATOR);
			item_s1.data    <= text_byte;
		end
	end

endmodule

// ===== hdl/sfm_queue.sv =====
module sfm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sfm_pkg::item_t        push_item,
	input  logic                  pop,
	output sfm_pkg::queue_status_t status
);

	sfm_pkg::item_t                   entry_q [sfm_pkg::QUEUE_DEPTH];
	logic [sfm_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [sfm_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [sfm_pkg::QCNT_BITS-1:0]    count_q;
	logic                             do_push;
	logic                             do_pop;

	assign status.full  = (count_q == sfm_pkg::QCNT_BITS'(sfm_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.head  = entry_q[rd_ptr_q];

	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/sfm_back.sv =====
module sfm_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sfm_pkg::cfg_t                    cfg,
	input  sfm_pkg::queue_status_t           q_status,
	output logic                             q_pop,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic                             found,
	output logic [sfm_pkg::OUT_POS_BITS-1:0] match_position,
	output logic                             too_long
);

	localparam int NB = sfm_pkg::BYTE_BITS;
	localparam int MN = sfm_pkg::MAX_NEEDLE;

	logic [NB-1:0]                    window_q [MN];
	logic [NB-1:0]                    win_new  [MN];
	logic [sfm_pkg::CNT_BITS-1:0]     bytes_seen_q;
	logic                             match_seen_q;
	logic [sfm_pkg::POSITION_BITS-1:0] first_start_q;

	logic                             out_valid_q;
	logic                             found_q;
	logic [sfm_pkg::OUT_POS_BITS-1:0] pos_q;
	logic                             too_long_q;

	logic                             out_free;
	logic                             do_byte;
	logic                             do_term;
	logic                             saturated;
	logic [sfm_pkg::CNT_BITS-1:0]     n;
	logic [sfm_pkg::LEN_BITS-1:0]     len;
	logic [MN:0]                      match_len;
	logic                             hit;

	assign out_free  = !out_valid_q || !result_stall;
	assign q_pop     = !q_status.empty && (!q_status.head.is_term || out_free);
	assign do_byte   = q_pop && !q_status.head.is_term;
	assign do_term   = q_pop && q_status.head.is_term;
	assign saturated = bytes_seen_q[sfm_pkg::POSITION_BITS];
	assign n         = bytes_seen_q + 1'b1;
	assign len       = sfm_pkg::eff_len(cfg.needle, cfg.length);

	// window after shifting in the head byte, newest at index 0
	always_comb begin
		win_new[0] = q_status.head.data;
		for (int k = 1; k < MN; k++) begin
			win_new[k] = window_q[k-1];
		end
	end

	// one compare lane per candidate needle length, all in parallel
	always_comb begin
		match_len = '0;
		for (int l = 1; l <= MN; l++) begin
			match_len[l] = 1'b1;
			for (int i = 0; i < MN; i++) begin
				if (i < l) begin
					if (win_new[l-1-i] != cfg.needle[i*NB +: NB]) begin
						match_len[l] = 1'b0;
					end
				end
			end
		end
	end

	assign hit = (len != '0) && (n >= sfm_pkg::CNT_BITS'(len)) && match_len[len];

	// window entries older than the current string never reach a compare:
	// the n >= len guard keeps them out, so no reset or clear is needed
	always_ff @(posedge clk) begin
		if (do_byte) begin
			for (int k = 0; k < MN; k++) begin
				window_q[k] <= win_new[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q  <= '0;
			match_seen_q  <= 1'b0;
			first_start_q <= '0;
		end else if (do_term) begin
			bytes_seen_q  <= '0;
			match_seen_q  <= 1'b0;
			first_start_q <= '0;
		end else if (do_byte && !saturated) begin
			bytes_seen_q <= n;
			if (!match_seen_q) begin
				if (len == '0) begin
					match_seen_q  <= 1'b1;
					first_start_q <= '0;
				end else if (hit) begin
					match_seen_q  <= 1'b1;
					first_start_q <= sfm_pkg::POSITION_BITS'(n - sfm_pkg::CNT_BITS'(len));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_term) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_term) begin
			found_q    <= match_seen_q;
			pos_q      <= match_seen_q ? sfm_pkg::OUT_POS_BITS'(first_start_q) : '0;
			too_long_q <= saturated;
		end
	end

	assign result_valid   = out_valid_q;
	assign found          = found_q;
	assign match_position = pos_q;
	assign too_long       = too_long_q;

endmodule

// ===== hdl/substring_first_match_top.sv =====
// First-match substring search over a streamed, zero-terminated haystack.
// Load the needle (up to eight nonzero bytes, first byte in bits 7..0 of
// register 0) and its length (register 1) while the block is idle; a length
// above eight is clamped and a zero byte inside the needle ends it early.
// Then feed the haystack one byte per beat on text_*. Every nonzero byte is
// shifted into an eight-byte window that is compared combinationally with the
// needle; the offset of the first complete match is kept. A zero byte ends
// the string and produces exactly one result beat on result_*: found, the
// match offset (zero when not found) and too_long, which is set once the
// haystack reached 2^16 bytes (later matches are then ignored). An empty
// needle matches at offset 0 for any nonempty haystack. Rate: one byte per
// cycle sustained while result_stall does not back up the queue. A terminator
// passes the input stage, the four-entry queue and the compare and result
// register before its result beat. The compare unit retires one queue entry
// per cycle; a terminator waits in the queue only while the previous result
// is still held by result_stall, and the input stalls once the queue fills.
module substring_first_match_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sfm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sfm_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// haystack bytes
	input  logic                              text_valid,
	output logic                              text_stall,
	input  logic [sfm_pkg::BYTE_BITS-1:0]     text_byte,
	// search results
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              found,
	output logic [sfm_pkg::OUT_POS_BITS-1:0]  match_position,
	output logic                              too_long
);

	sfm_pkg::cfg_t          cfg_q;
	sfm_pkg::queue_status_t q_status;
	sfm_pkg::item_t         q_item;
	logic                   q_push;
	logic                   q_pop;

	// config regs always accept a beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfm_pkg::REG_NEEDLE_BYTES: begin
					cfg_q.needle <= sfm_pkg::NEEDLE_BITS'(cfg_data);
				end
				sfm_pkg::REG_NEEDLE_LENGTH: begin
					cfg_q.length <= cfg_data[sfm_pkg::CFG_LEN_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front: registers and classifies each beat (terminator or data)
	sfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.q_full     (q_status.full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	// short queue decouples input stalls from result stalls
	sfm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.status    (q_status)
	);

	// back: window compare, match tracking, result register
	sfm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_status       (q_status),
		.q_pop          (q_pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.found          (found),
		.match_position (match_position),
		.too_long       (too_long)
	);

endmodule
